// ----- hw/rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: widths, register
// indexes, status codes, sequencer states and the control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

   // number format
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // derived widths
   localparam int CFG_WIDTH   = DATA_WIDTH - 1;
   localparam int GAIN_WIDTH  = FRAC_BITS + 1;
   localparam int DEN_WIDTH   = DATA_WIDTH + 1;
   localparam int MAG_WIDTH   = DATA_WIDTH + 1;
   localparam int PROD_WIDTH  = MAG_WIDTH + GAIN_WIDTH;
   localparam int COUNT_WIDTH = $clog2(FRAC_BITS + 1);
   localparam int INDEX_WIDTH = 8;
   localparam int STATUS_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = ((DATA_WIDTH + GAIN_WIDTH + 7) / 8) * 8;

   // gain of 1.0
   localparam logic [GAIN_WIDTH-1:0] ONE_FX = GAIN_WIDTH'(1) << FRAC_BITS;

   // register reset values
   localparam logic [CFG_WIDTH-1:0]  RESET_PROCESS_NOISE     = CFG_WIDTH'(6554);
   localparam logic [CFG_WIDTH-1:0]  RESET_MEASUREMENT_NOISE = CFG_WIDTH'(6554);
   localparam logic [DATA_WIDTH-1:0] RESET_INITIAL_ESTIMATE  = '0;
   localparam logic [CFG_WIDTH-1:0]  RESET_INITIAL_COVARIANCE = CFG_WIDTH'(6554);

   // register indexes
   localparam logic [INDEX_WIDTH-1:0] REG_PROCESS_NOISE      = INDEX_WIDTH'(0);
   localparam logic [INDEX_WIDTH-1:0] REG_MEASUREMENT_NOISE  = INDEX_WIDTH'(1);
   localparam logic [INDEX_WIDTH-1:0] REG_INITIAL_ESTIMATE   = INDEX_WIDTH'(2);
   localparam logic [INDEX_WIDTH-1:0] REG_INITIAL_COVARIANCE = INDEX_WIDTH'(3);

   // status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_DIV_ZERO  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SATURATED = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_DENOM,
      ST_DIVIDE,
      ST_MUL_CORR,
      ST_UPD_X,
      ST_UPD_P,
      ST_RESPOND
   } skf_state_type;

   // control bundle from the sequencer to the datapath
   typedef struct packed {
      logic in_ready;
      logic predict;
      logic denom;
      logic take_gain;
      logic mul_cov;
      logic upd_x;
      logic upd_p;
      logic respond;
   } skf_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div
// Iterative restoring divider for the gain: quo = floor(num * 2^F / den)
// with num <= den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [skf_pkg::DATA_WIDTH-1:0]    num,
   input  wire logic [skf_pkg::DEN_WIDTH-1:0]     den,
   output logic      [skf_pkg::GAIN_WIDTH-1:0]    quo,
   output logic                                   last
);
   import skf_pkg::*;

   logic                   busy_ff, busy_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DEN_WIDTH-1:0]   rem_ff, rem_in;
   logic [DEN_WIDTH-1:0]   den_ff, den_in;
   logic [GAIN_WIDTH-1:0]  quo_ff, quo_in;
   logic [DEN_WIDTH:0]     trial;
   logic [DEN_WIDTH:0]     diff;
   logic                   fits;

   // one compare and subtract step; the first step has no shift
   always_comb begin
      trial = (count_ff == '0) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
      last  = busy_ff && (count_ff == COUNT_WIDTH'(FRAC_BITS));
   end

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = {1'b0, num};
         den_in   = den;
         quo_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
         quo_in   = {quo_ff[GAIN_WIDTH-2:0], fits};
         count_in = count_ff + COUNT_WIDTH'(1);
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul
// Shared registered multiplier, used for the correction term and for the
// covariance update.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul (
   input  wire logic                              clock,
   input  wire logic [skf_pkg::MAG_WIDTH-1:0]     mul_a,
   input  wire logic [skf_pkg::GAIN_WIDTH-1:0]    mul_b,
   output logic      [skf_pkg::PROD_WIDTH-1:0]    product
);
   import skf_pkg::*;

   logic [PROD_WIDTH-1:0] product_ff, product_in;

   // unsigned product
   always_comb begin
      product_in = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
   end

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/skf_ctrl.sv -----
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer of one filter step: predict, denominator, gain division,
// correction multiply, estimate and covariance update, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  den_zero,
   input  wire logic                  div_last,
   input  wire logic                  rsp_free,
   output skf_pkg::skf_ctrl_type      ctrl
);
   import skf_pkg::*;

   skf_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_PREDICT;
         ST_PREDICT:  state_in = ST_DENOM;
         ST_DENOM:    state_in = den_zero ? ST_RESPOND : ST_DIVIDE;
         ST_DIVIDE:   if (div_last) state_in = ST_MUL_CORR;
         ST_MUL_CORR: state_in = ST_UPD_X;
         ST_UPD_X:    state_in = ST_UPD_P;
         ST_UPD_P:    state_in = ST_RESPOND;
         ST_RESPOND:  if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE:     ctrl.in_ready  = 1'b1;
         ST_PREDICT:  ctrl.predict   = 1'b1;
         ST_DENOM:    ctrl.denom     = 1'b1;
         ST_DIVIDE:   ctrl = '0;
         ST_MUL_CORR: ctrl.take_gain = 1'b1;
         ST_UPD_X: begin
            ctrl.upd_x   = 1'b1;
            ctrl.mul_cov = 1'b1;
         end
         ST_UPD_P:    ctrl.upd_p     = 1'b1;
         ST_RESPOND:  ctrl.respond   = rsp_free;
         default:     ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// Scalar Kalman filter in signed Q16.16: one predict/update step per sample,
// result carries the new estimate, the gain and a status.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   req_      in         req_tvalid/tready     tdata sample, tuser restart,
//                                              tlast last_in_block
//   rsp_      out        rsp_tvalid/tready     tdata filtered, gain,
//                                              tuser status, tlast last_out
//   csr_      in         csr_valid/ready       csr_index, csr_data
//
// a new sample is taken only once the previous step has been handed off; the gain
// divider is serial, and a zero denominator skips the division and the updates
// the result waits in an output register, so a stalled rsp_ side holds the
// block only in its final hand-off state
// reset loads the registers with their defaults and the state from them
// configuration writes are always taken (csr_ready is high)
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: [31:0] sample
   input  wire logic [skf_pkg::DATA_WIDTH-1:0]      req_tdata,
   // request: [0] restart
   input  wire logic                                req_tuser,
   input  wire logic                                req_tlast,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // response: [31:0] filtered, [48:32] gain, [55:49] zero
   output logic [skf_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   // response: [1:0] status
   output logic [skf_pkg::STATUS_WIDTH-1:0]         rsp_tuser,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [skf_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [skf_pkg::DATA_WIDTH-1:0]      csr_data
);
   import skf_pkg::*;

   skf_ctrl_type ctrl;

   // configuration registers
   logic [CFG_WIDTH-1:0]  q_ff, q_in;
   logic [CFG_WIDTH-1:0]  r_ff, r_in;
   logic [DATA_WIDTH-1:0] init_x_ff, init_x_in;
   logic [CFG_WIDTH-1:0]  init_p_ff, init_p_in;

   // filter state and step registers
   logic [DATA_WIDTH-1:0]   x_ff, x_in;
   logic [DATA_WIDTH-1:0]   p_ff, p_in;
   logic [DATA_WIDTH-1:0]   sample_ff, sample_in;
   logic                    last_ff, last_in;
   logic [GAIN_WIDTH-1:0]   k_ff, k_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [MAG_WIDTH-1:0]    mag_ff, mag_in;
   logic                    neg_ff, neg_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_x_ff, rsp_x_in;
   logic [GAIN_WIDTH-1:0]   rsp_k_ff, rsp_k_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // datapath nets
   logic                  req_accept;
   logic                  rsp_free;
   logic [DATA_WIDTH:0]   p_sum;
   logic [DEN_WIDTH-1:0]  den;
   logic                  den_zero;
   logic [MAG_WIDTH-1:0]  diff;
   logic [GAIN_WIDTH-1:0] div_quo;
   logic                  div_last;
   logic [MAG_WIDTH-1:0]  mul_a;
   logic [GAIN_WIDTH-1:0] mul_b;
   logic [PROD_WIDTH-1:0] product;
   logic [MAG_WIDTH-1:0]  corr;
   logic [MAG_WIDTH:0]    x_sum;
   logic                  x_over;
   logic                  x_under;

   assign csr_ready  = 1'b1;
   assign req_tready = ctrl.in_ready;
   assign req_accept = req_tvalid && ctrl.in_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // step sequencer
   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .den_zero  (den_zero),
      .div_last  (div_last),
      .rsp_free  (rsp_free),
      .ctrl      (ctrl)
   );

   // gain divider
   skf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.denom && !den_zero),
      .num   (p_ff),
      .den   (den),
      .quo   (div_quo),
      .last  (div_last)
   );

   // shared multiplier: correction term, then covariance update
   always_comb begin
      if (ctrl.mul_cov) begin
         mul_a = {1'b0, p_ff};
         mul_b = ONE_FX - k_ff;
      end else begin
         mul_a = mag_ff;
         mul_b = div_quo;
      end
   end

   skf_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // arithmetic around the shared units
   always_comb begin
      p_sum    = {1'b0, p_ff} + {2'b0, q_ff};
      den      = {1'b0, p_ff} + {2'b0, r_ff};
      den_zero = (den == '0);
      diff     = {sample_ff[DATA_WIDTH-1], sample_ff} - {x_ff[DATA_WIDTH-1], x_ff};
      corr     = product[FRAC_BITS +: MAG_WIDTH];
      x_sum    = {{2{x_ff[DATA_WIDTH-1]}}, x_ff}
               + (neg_ff ? -{1'b0, corr} : {1'b0, corr});
      x_over   = !x_sum[MAG_WIDTH] && (x_sum[MAG_WIDTH-1:DATA_WIDTH-1] != '0);
      x_under  = x_sum[MAG_WIDTH] && (x_sum[MAG_WIDTH-1:DATA_WIDTH-1] != '1);
   end

   // configuration writes
   always_comb begin
      q_in      = q_ff;
      r_in      = r_ff;
      init_x_in = init_x_ff;
      init_p_in = init_p_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PROCESS_NOISE:      q_in      = csr_data[CFG_WIDTH-1:0];
            REG_MEASUREMENT_NOISE:  r_in      = csr_data[CFG_WIDTH-1:0];
            REG_INITIAL_ESTIMATE:   init_x_in = csr_data;
            REG_INITIAL_COVARIANCE: init_p_in = csr_data[CFG_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // filter step
   always_comb begin
      x_in      = x_ff;
      p_in      = p_ff;
      sample_in = sample_ff;
      last_in   = last_ff;
      k_in      = k_ff;
      status_in = status_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      if (req_accept) begin
         sample_in = req_tdata;
         last_in   = req_tlast;
         if (req_tuser) begin
            x_in = init_x_ff;
            p_in = {1'b0, init_p_ff};
         end
      end
      if (ctrl.predict) begin
         p_in      = p_sum[DATA_WIDTH] ? '1 : p_sum[DATA_WIDTH-1:0];
         k_in      = '0;
         status_in = STATUS_OK;
      end
      if (ctrl.denom) begin
         neg_in = diff[MAG_WIDTH-1];
         mag_in = diff[MAG_WIDTH-1] ? -diff : diff;
         if (den_zero) begin
            status_in = STATUS_DIV_ZERO;
         end
      end
      if (ctrl.take_gain) begin
         k_in = div_quo;
      end
      if (ctrl.upd_x) begin
         if (x_over) begin
            x_in      = {1'b0, {(DATA_WIDTH-1){1'b1}}};
            status_in = STATUS_SATURATED;
         end else if (x_under) begin
            x_in      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
            status_in = STATUS_SATURATED;
         end else begin
            x_in = x_sum[DATA_WIDTH-1:0];
         end
      end
      if (ctrl.upd_p) begin
         p_in = product[FRAC_BITS +: DATA_WIDTH];
      end
   end

   // result hand-off
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_x_in      = rsp_x_ff;
      rsp_k_in      = rsp_k_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (ctrl.respond) begin
         rsp_valid_in  = 1'b1;
         rsp_x_in      = x_ff;
         rsp_k_in      = k_ff;
         rsp_status_in = status_ff;
         rsp_last_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= RESET_PROCESS_NOISE;
         r_ff         <= RESET_MEASUREMENT_NOISE;
         init_x_ff    <= RESET_INITIAL_ESTIMATE;
         init_p_ff    <= RESET_INITIAL_COVARIANCE;
         x_ff         <= RESET_INITIAL_ESTIMATE;
         p_ff         <= {1'b0, RESET_INITIAL_COVARIANCE};
         rsp_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         r_ff         <= r_in;
         init_x_ff    <= init_x_in;
         init_p_ff    <= init_p_in;
         x_ff         <= x_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_k_ff      <= rsp_k_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_k_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- tb/sv/tb_scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// Self-checking bench for the scalar Kalman filter. Each accepted measurement
// runs one predict/update step on a shadow copy of estimate and covariance;
// every response is compared field by field with the oldest expected step.
// Directed steps cover field extremes, restart, register masking, unmapped
// register writes and the zero-denominator case; random phases then sweep
// noise settings with random idle and stall on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scalar_kalman_filter;
   import skf_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int HOLD_CYCLES     = 300;
   localparam int HOLD_AT_RESULT  = 400;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 125;

   localparam logic [INDEX_WIDTH-1:0] REG_FIRST_UNMAPPED = INDEX_WIDTH'(4);
   localparam logic [DATA_WIDTH-1:0]  NOISE_MAX  = {1'b0, {CFG_WIDTH{1'b1}}};
   localparam logic [DATA_WIDTH-1:0]  SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0]  SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam longint unsigned CFG_MASK = (64'd1 << CFG_WIDTH) - 1;
   localparam longint unsigned COV_MAX  = (64'd1 << DATA_WIDTH) - 1;
   localparam longint EST_MAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint EST_MIN = -EST_MAX - 1;

   // one expected filter step
   typedef struct {
      logic [DATA_WIDTH-1:0]   filtered;
      logic [GAIN_WIDTH-1:0]   gain;
      logic [STATUS_WIDTH-1:0] status;
      logic                    last;
   } kalman_step_type;

   // shadow filter state and the queue of steps still owed by the block
   class kalman_scoreboard;
      longint unsigned       process_noise;
      longint unsigned       measurement_noise;
      longint unsigned       initial_covariance;
      logic [DATA_WIDTH-1:0] initial_estimate;
      longint                est;
      longint unsigned       cov;
      kalman_step_type       expected_steps[$];
      int                    mismatches;
      int                    results_seen;

      function new();
         process_noise      = RESET_PROCESS_NOISE;
         measurement_noise  = RESET_MEASUREMENT_NOISE;
         initial_estimate   = RESET_INITIAL_ESTIMATE;
         initial_covariance = RESET_INITIAL_COVARIANCE;
         mismatches         = 0;
         results_seen       = 0;
         reload();
      endfunction

      // load estimate and covariance from their registers
      function void reload();
         est = longint'($signed(initial_estimate));
         cov = (initial_covariance > COV_MAX) ? COV_MAX : initial_covariance;
      endfunction

      function void set_register(logic [INDEX_WIDTH-1:0] index,
                                 logic [DATA_WIDTH-1:0] value);
         case (index)
            REG_PROCESS_NOISE:      process_noise      = value & CFG_MASK;
            REG_MEASUREMENT_NOISE:  measurement_noise  = value & CFG_MASK;
            REG_INITIAL_ESTIMATE:   initial_estimate   = value;
            REG_INITIAL_COVARIANCE: initial_covariance = value & CFG_MASK;
            default: ;
         endcase
      endfunction

      // one predict/update step for an accepted measurement
      function void note_sample(logic [DATA_WIDTH-1:0] meas, bit restart, bit last);
         kalman_step_type step;
         longint unsigned den, k, mag, corr;
         longint          diff, x_next;
         step.status = STATUS_OK;
         k = 0;
         if (restart) reload();
         cov = cov + process_noise;
         if (cov > COV_MAX) cov = COV_MAX;
         den = cov + measurement_noise;
         if (den == 0) begin
            step.status = STATUS_DIV_ZERO;
         end else begin
            k    = (cov << FRAC_BITS) / den;
            diff = longint'($signed(meas)) - est;
            mag  = (diff < 0) ? -diff : diff;
            // correction magnitude truncated, sign put back afterwards
            corr = (mag * k) >> FRAC_BITS;
            x_next = (diff < 0) ? est - longint'(corr) : est + longint'(corr);
            if (x_next > EST_MAX) begin
               x_next = EST_MAX;
               step.status = STATUS_SATURATED;
            end else if (x_next < EST_MIN) begin
               x_next = EST_MIN;
               step.status = STATUS_SATURATED;
            end
            est = x_next;
            cov = (cov * (ONE_FX - k)) >> FRAC_BITS;
         end
         step.filtered = est[DATA_WIDTH-1:0];
         step.gain     = k[GAIN_WIDTH-1:0];
         step.last     = last;
         expected_steps.push_back(step);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_step(logic [RSP_DATA_WIDTH-1:0] tdata,
                               logic [STATUS_WIDTH-1:0] tuser, logic tlast);
         kalman_step_type step;
         results_seen++;
         if (expected_steps.size() == 0) begin
            $error("response with no measurement pending: tdata %0h", tdata);
            mismatches++;
            return;
         end
         step = expected_steps.pop_front();
         compare_field("filtered", step.filtered, tdata[DATA_WIDTH-1:0]);
         compare_field("gain", step.gain, tdata[DATA_WIDTH +: GAIN_WIDTH]);
         compare_field("tdata padding", '0, tdata >> (DATA_WIDTH + GAIN_WIDTH));
         compare_field("status", step.status, tuser);
         compare_field("last_out", step.last, tlast);
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   // request: [31:0] sample
   logic [DATA_WIDTH-1:0]       req_tdata = '0;
   // request: [0] restart
   logic                        req_tuser = 1'b0;
   logic                        req_tlast = 1'b0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   // response: [31:0] filtered, [48:32] gain, [55:49] zero
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   // response: [1:0] status
   logic [STATUS_WIDTH-1:0]     rsp_tuser;
   logic                        rsp_tlast;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [INDEX_WIDTH-1:0]      csr_index = '0;
   logic [DATA_WIDTH-1:0]       csr_data = '0;

   kalman_scoreboard sb;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   bit hold_done  = 1'b0;

   scalar_kalman_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // offer one measurement after a random gap and wait for its transaction
   task automatic send_sample(logic [DATA_WIDTH-1:0] meas, bit restart, bit last);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= meas;
      req_tuser  <= restart;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(meas, restart, last);
   endtask

   // single register write; the caller drops csr_valid after the batch
   task automatic write_reg(logic [INDEX_WIDTH-1:0] index, logic [DATA_WIDTH-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(index, value);
   endtask

   task automatic apply_settings(logic [DATA_WIDTH-1:0] q, logic [DATA_WIDTH-1:0] r,
                                 logic [DATA_WIDTH-1:0] x0, logic [DATA_WIDTH-1:0] p0);
      // an unmapped index must leave every register alone
      write_reg(INDEX_WIDTH'($urandom_range(REG_FIRST_UNMAPPED, (1 << INDEX_WIDTH) - 1)),
                $urandom);
      write_reg(REG_PROCESS_NOISE, q);
      write_reg(REG_MEASUREMENT_NOISE, r);
      write_reg(REG_INITIAL_ESTIMATE, x0);
      write_reg(REG_INITIAL_COVARIANCE, p0);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response side: random stall per transaction, one long hold-off
   task automatic take_results();
      int stall;
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 5);
         if (!hold_done && sb.results_seen >= HOLD_AT_RESULT) begin
            stall = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_step(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   endtask

   // extremes, small values around zero, full random or close to the estimate
   function automatic logic [DATA_WIDTH-1:0] pick_sample();
      logic [63:0] current;
      current = sb.est;
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return DATA_WIDTH'($urandom_range(0, 2)) - DATA_WIDTH'(1);
         3, 4, 5: return $urandom;
         default: return current[DATA_WIDTH-1:0] + DATA_WIDTH'($urandom_range(0, 1 << 20))
                         - DATA_WIDTH'(1 << 19);
      endcase
   endfunction

   // used for both noises and the initial covariance; full random may set bit 31
   function automatic logic [DATA_WIDTH-1:0] pick_noise();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return NOISE_MAX;
         2: return DATA_WIDTH'($urandom_range(0, 16));
         3: return DATA_WIDTH'($urandom_range(0, 1 << 20));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_estimate();
      case ($urandom_range(0, 4))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         default: return $urandom;
      endcase
   endfunction

   // watchdog: too long without any transaction ends the run
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // main sequence
   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      fork
         take_results();
      join_none

      // reset settings: field extremes, restart and last flags
      send_sample('0, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0, 1'b0);
      send_sample('1, 1'b0, 1'b0);
      send_sample(DATA_WIDTH'(1), 1'b1, 1'b0);
      send_sample({(DATA_WIDTH/2){2'b01}}, 1'b1, 1'b1);
      send_sample({(DATA_WIDTH/2){2'b10}}, 1'b0, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // all-ones writes get masked; noise and covariance at their ceilings
      apply_settings('1, NOISE_MAX, SAMPLE_MIN, '1);
      send_sample(SAMPLE_MAX, 1'b1, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0, 1'b0);
      send_sample('0, 1'b0, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // no noise and no covariance: zero denominator, estimate held
      apply_settings('0, '0, SAMPLE_MAX, '0);
      send_sample(SAMPLE_MIN, 1'b1, 1'b0);
      send_sample(DATA_WIDTH'(1), 1'b0, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // tiny covariance without noise: unit gain, then zero denominator
      apply_settings('0, '0, '0, DATA_WIDTH'(1));
      send_sample(SAMPLE_MIN, 1'b1, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0, 1'b0);
      send_sample('1, 1'b0, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // unit process noise against zero measurement noise
      apply_settings(DATA_WIDTH'(1), '0, SAMPLE_MIN, '0);
      send_sample(SAMPLE_MAX, 1'b1, 1'b0);
      send_sample('0, 1'b0, 1'b1);
      req_tvalid <= 1'b0;

      // random phases, each under fresh settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         logic [DATA_WIDTH-1:0] q, r;
         q = pick_noise();
         r = pick_noise();
         if (phase == 0) begin
            q = NOISE_MAX;
            r = NOISE_MAX;
         end else if (phase == 1) begin
            q = '0;
            r = '0;
         end
         wait_drained();
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         apply_settings(q, r, pick_estimate(), pick_noise());
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(pick_sample(), (n == 0) || ($urandom_range(0, 19) == 0),
                        $urandom_range(0, 7) == 0);
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
